// ===== design/spectrum_peak_magnitude_finder_assert.svh =====
// Assertion macros shared by the spectrum peak magnitude finder checker.
`ifndef SPECTRUM_PEAK_MAGNITUDE_FINDER_ASSERT_SVH
`define SPECTRUM_PEAK_MAGNITUDE_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPMF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spmf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spmf assertion failed");

`endif

// ===== design/spmf_pkg.sv =====
// Shared types, constants and helpers of the spectrum peak magnitude finder.
`default_nettype none
package spmf_pkg;

  localparam int unsigned BINS_PER_FRAME = 256;
  localparam int unsigned MAG_W          = 15;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned BIN_W          = 10;
  localparam int unsigned SQRT_STEPS     = 31;
  localparam int unsigned STEP_W         = 5;
  localparam int unsigned MAG_SHIFT      = 14;
  localparam logic [MAG_W-1:0] MAG_MAX   = 15'h7FFF;
  localparam logic [BIN_W-1:0] NO_BIN    = 10'd512;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } mag_res_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(~v + 16'sd1) : 16'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/spmf_mag.sv =====
// Iterative magnitude unit: shared squarer, then a 31-step two-bit restoring square root.
`default_nettype none
module spmf_mag
  import spmf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] re,
  input  wire logic signed [15:0] im,
  output mag_res_t                res
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_SQ   = 3'b010,
    M_ROOT = 3'b100
  } mag_state_t;

  mag_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic [15:0]       im_abs_r;
  logic [31:0]       acc_r;
  logic [31:0]       rem_hi_r;
  logic [31:0]       rem_lo_r;
  logic [31:0]       root_r;
  logic              done_r;
  logic [MAG_W-1:0]  mag_r;

  logic [15:0] mul_op;
  logic [31:0] mul_p;
  logic [31:0] hi_s, lo_s, root_s, trial, hi_n, root_n, shr;
  logic        ge, last_step;

  assign mul_op = (state_r == M_IDLE) ? abs16(re) : im_abs_r;
  assign mul_p  = 32'(mul_op) * 32'(mul_op);

  assign hi_s      = {rem_hi_r[29:0], rem_lo_r[31:30]};
  assign lo_s      = {rem_lo_r[29:0], 2'b00};
  assign root_s    = {root_r[30:0], 1'b0};
  assign trial     = {root_s[30:0], 1'b1};
  assign ge        = hi_s >= trial;
  assign hi_n      = ge ? (hi_s - trial) : hi_s;
  assign root_n    = {root_s[31:1], ge};
  assign shr       = root_n >> MAG_SHIFT;
  assign last_step = (cnt_r == STEP_W'(SQRT_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE: if (start) state_nxt = M_SQ;
      M_SQ:   state_nxt = M_ROOT;
      M_ROOT: if (last_step) state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == M_ROOT) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      M_IDLE: begin
        acc_r    <= mul_p;
        im_abs_r <= abs16(im);
      end
      M_SQ: begin
        rem_lo_r <= acc_r + mul_p;
        rem_hi_r <= '0;
        root_r   <= '0;
        cnt_r    <= '0;
      end
      M_ROOT: begin
        rem_hi_r <= hi_n;
        rem_lo_r <= lo_s;
        root_r   <= root_n;
        cnt_r    <= cnt_r + STEP_W'(1);
        if (last_step) begin
          mag_r <= (shr > 32'(MAG_MAX)) ? MAG_MAX : shr[MAG_W-1:0];
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  assign res.done = done_r;
  assign res.mag  = mag_r;

endmodule
`default_nettype wire

// ===== design/spectrum_peak_magnitude_finder.sv =====
// Spectrum peak magnitude finder top level: request sequencer, peak tracker, output register.
//
// The input channel takes one complex bin per request: in_tdata carries the
// real part in bits 15:0 and the imaginary part in bits 31:16, and in_tlast
// marks the final bin of a frame. The result channel returns one result per
// bin with its saturated magnitude, its position in the frame, and the peak
// magnitude and peak bin so far; out_tlast is set on the frame's final result.
// A bin is accepted only while the block is idle. The shared multiplier
// squares the real part as the bin is accepted and the imaginary part in
// the next state; the root unit then takes one two-bit step per cycle. The
// next bin can be taken once the result enters the output register.
// The output register lets the block take the next bin while a result waits.
// If the receiver stalls, the finished magnitude is held until the output
// register frees, and in_tready stays low meanwhile.
// Reset clears the peak to zero, the peak bin to 512 (no bin found), the bin
// position to zero, and drops out_tvalid.
`default_nettype none
module spectrum_peak_magnitude_finder
  import spmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // real_part[15:0], imag_part[31:16]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // bin_magnitude[14:0], bin_number[22:15],
                                       // peak_magnitude[37:23], peak_bin[47:38]
  output logic             out_tlast
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  top_state_t       state_r, state_nxt;
  logic             last_r;
  logic [MAG_W-1:0] best_r;
  logic [BIN_W-1:0] best_bin_r;
  logic [POS_W-1:0] pos_r;
  logic             out_valid_r;
  logic [47:0]      out_data_r;
  logic             out_last_r;

  mag_res_t         res;
  logic             accept, slot_free, commit, gt;
  logic [MAG_W-1:0] peak_mag;
  logic [BIN_W-1:0] peak_bin, pos_inc;

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign commit    = slot_free && (((state_r == T_BUSY) && res.done) || (state_r == T_HOLD));

  spmf_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .re    (in_tdata[15:0]),
    .im    (in_tdata[31:16]),
    .res   (res)
  );

  assign gt       = res.mag > best_r;
  assign peak_mag = gt ? res.mag : best_r;
  assign peak_bin = gt ? BIN_W'(pos_r) : best_bin_r;
  assign pos_inc  = BIN_W'(pos_r) + BIN_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (accept) state_nxt = T_BUSY;
      T_BUSY: begin
        if (res.done) state_nxt = commit ? T_IDLE : T_HOLD;
      end
      T_HOLD: if (commit) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      best_r      <= '0;
      best_bin_r  <= NO_BIN;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        if (last_r) begin
          best_r     <= '0;
          best_bin_r <= NO_BIN;
          pos_r      <= '0;
        end else begin
          best_r     <= peak_mag;
          best_bin_r <= peak_bin;
          pos_r      <= (pos_inc >= BIN_W'(BINS_PER_FRAME)) ? '0 : pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_tlast;
    end
    if (commit) begin
      out_data_r <= {peak_bin, peak_mag, pos_r, res.mag};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== design/spmf_checker.sv =====
// Port-level checker for the spectrum peak magnitude finder, bound to the top level.
`default_nettype none
`include "spectrum_peak_magnitude_finder_assert.svh"
module spmf_checker
  import spmf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast
);

  logic in_acc, out_stall, no_peak, zero_peak, in_seen;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign no_peak   = (out_tdata[47:38] == NO_BIN);
  assign zero_peak = (out_tdata[37:23] == '0);
  assign in_seen   = in_tlast || (in_tdata != '0) || !in_tlast;

  `SPMF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready && in_seen)
  `SPMF_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stall,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `SPMF_ASSERT_SAME(a_no_peak_zero, clk, rst_n, out_tvalid, no_peak == zero_peak)
  `SPMF_ASSERT_SAME(a_peak_covers_bin, clk, rst_n, out_tvalid,
                    out_tdata[37:23] >= out_tdata[14:0])

endmodule

bind spectrum_peak_magnitude_finder spmf_checker u_spmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
